FILE: design/cdps_pkg.sv
// Shared types, codes and constants of the CiA 402 drive power sequencer.
`timescale 1ns / 1ps

package cdps_pkg;

    // Queue between the front and back parts.
    localparam int CDPS_QUEUE_DEPTH = 4;

    // Stream and register port widths.
    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 104;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Request kinds as carried on s_tuser.
    typedef enum logic [1:0] {
        REQ_POWER = 2'd0,
        REQ_RESET = 2'd1,
        REQ_BUS   = 2'd2,
        REQ_NONE  = 2'd3
    } req_kind_t;

    // Classes produced by the front part for the back part.
    typedef enum logic [2:0] {
        CLS_IDLE      = 3'd0,
        CLS_LINK_LOST = 3'd1,
        CLS_POWER     = 3'd2,
        CLS_RESET     = 3'd3,
        CLS_BUS       = 3'd4
    } item_class_t;

    // Register indexes (byte address is four times the index).
    typedef enum logic [1:0] {
        REG_DRIVE_MODE     = 2'd0,
        REG_FIELDBUS_READY = 2'd1,
        REG_HOME_ENABLE    = 2'd2,
        REG_MAX_PROFILE_V  = 2'd3
    } reg_index_t;

    // Drive modes selected by the drive_mode register.
    typedef enum logic [1:0] {
        DM_CSP    = 2'd0,
        DM_CSV    = 2'd1,
        DM_CST    = 2'd2,
        DM_HOMING = 2'd3
    } drive_mode_t;

    // Error codes reported on power and reset requests.
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_FIELDBUS_INIT = 3'd1;
    localparam logic [2:0] ERR_POWERED_ON    = 3'd2;
    localparam logic [2:0] ERR_POWER_ON      = 3'd3;
    localparam logic [2:0] ERR_POWER_OFF     = 3'd4;

    // Control words sent to the drive.
    localparam logic [7:0] CW_DISABLE_VOLTAGE = 8'h00;
    localparam logic [7:0] CW_SHUTDOWN        = 8'h06;
    localparam logic [7:0] CW_SWITCH_ON       = 8'h07;
    localparam logic [7:0] CW_ENABLE_OP       = 8'h0F;
    localparam logic [7:0] CW_FAULT_RESET     = 8'h80;
    localparam logic [7:0] CW_CLEAR_HOME      = 8'hEF;
    localparam logic [7:0] CW_HOME_START      = 8'h10;

    // Operation mode codes written to the drive.
    localparam logic [3:0] MSEL_CSP    = 4'd8;
    localparam logic [3:0] MSEL_CSV    = 4'd9;
    localparam logic [3:0] MSEL_CST    = 4'd10;
    localparam logic [3:0] MSEL_HOMING = 4'd6;
    localparam logic signed [7:0] ACT_MODE_HOMING = 8'sd6;

    // Status word masks and patterns.
    localparam logic [15:0] SW_MASK_4F  = 16'h004F;
    localparam logic [15:0] SW_MASK_7F  = 16'h007F;
    localparam logic [15:0] SW_MASK_6F  = 16'h006F;
    localparam logic [15:0] SW_MASK_7B  = 16'h007B;
    localparam logic [15:0] SW_OP_EN    = 16'h0037;
    localparam logic [15:0] SW_QSTOP    = 16'h0007;
    localparam logic [15:0] SW_NOT_RDY  = 16'h0000;
    localparam logic [15:0] SW_SW_DIS   = 16'h0040;
    localparam logic [15:0] SW_RDY      = 16'h0031;
    localparam logic [15:0] SW_SW_ON    = 16'h0033;
    localparam logic [15:0] SW_FAULT    = 16'h0008;
    localparam logic [15:0] SW_FAULT_RA = 16'h000F;

    // Input fields as packed in s_tdata, last field lowest.
    typedef struct packed {
        logic signed [15:0] submit_torque;
        logic signed [31:0] submit_velocity;
        logic signed [31:0] submit_position;
        logic signed [7:0]  actual_mode;
        logic signed [31:0] actual_position;
        logic               link_up;
        logic [15:0]        drive_status;
        logic               power_request;
    } in_fields_t;

    // Classified request held in the queue.
    typedef struct packed {
        item_class_t        cls;
        logic               power_request;
        logic [15:0]        drive_status;
        logic signed [31:0] actual_position;
        logic signed [7:0]  actual_mode;
        logic signed [31:0] submit_position;
        logic signed [31:0] submit_velocity;
        logic signed [15:0] submit_torque;
    } item_t;

    // Result fields as packed in m_tdata, last field lowest.
    typedef struct packed {
        logic [3:0]         mode_select;
        logic               mode_write;
        logic signed [15:0] target_torque;
        logic               torque_write;
        logic signed [31:0] target_velocity;
        logic               velocity_write;
        logic signed [31:0] target_position;
        logic               position_write;
        logic               servo_on;
        logic               done_res;
        logic [2:0]         error_code;
        logic [7:0]         control_word;
    } result_t;

    // Configuration seen by the back part.
    typedef struct packed {
        drive_mode_t drive_mode;
        logic        fieldbus_ready;
        logic        home_enable;
        logic [31:0] max_profile_velocity;
    } cfg_t;

    // Queue status towards the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // True when the status word shows a fault or a fault reaction.
    function automatic logic drive_faulted(input logic [15:0] sw);
        logic [15:0] m;
        m = sw & SW_MASK_4F;
        return (m == SW_FAULT_RA) || (m == SW_FAULT);
    endfunction

endpackage

FILE: design/cdps_front.sv
// Front part: takes requests from the input stream and classifies them.
`timescale 1ns / 1ps

module cdps_front
    import cdps_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  queue_status_t        q_status,
    output logic                 push,
    output item_t                push_item
);

    in_fields_t  fields;
    req_kind_t   kind;
    item_class_t cls;

    assign fields = in_fields_t'(s_tdata[$bits(in_fields_t)-1:0]);
    assign kind   = req_kind_t'(s_tuser);

    // A request is taken whenever the queue has room.
    assign s_tready = ~q_status.full;
    assign push     = s_tvalid & ~q_status.full;

    // Power and reset requests collapse into one class when the link is down.
    always_comb
    begin
        case (kind)
            REQ_POWER: cls = fields.link_up ? CLS_POWER : CLS_LINK_LOST;
            REQ_RESET: cls = fields.link_up ? CLS_RESET : CLS_LINK_LOST;
            REQ_BUS:   cls = CLS_BUS;
            default:   cls = CLS_IDLE;
        endcase
    end

    always_comb
    begin
        push_item.cls             = cls;
        push_item.power_request   = fields.power_request;
        push_item.drive_status    = fields.drive_status;
        push_item.actual_position = fields.actual_position;
        push_item.actual_mode     = fields.actual_mode;
        push_item.submit_position = fields.submit_position;
        push_item.submit_velocity = fields.submit_velocity;
        push_item.submit_torque   = fields.submit_torque;
    end

endmodule

FILE: design/cdps_queue.sv
// Short queue of classified requests between the front and back parts.
`timescale 1ns / 1ps

module cdps_queue
    import cdps_pkg::*;
#(
    parameter int DEPTH = CDPS_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         head_item,
    output queue_status_t q_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    item_t           slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign head_item      = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: design/cdps_back.sv
// Back part: power sequence, bus cycle handling and the output register.
`timescale 1ns / 1ps

module cdps_back
    import cdps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  queue_status_t        q_status,
    input  item_t                head_item,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        PH_OFF    = 3'd0,
        PH_EN_ON  = 3'd1,
        PH_ON     = 3'd2,
        PH_EN_OFF = 3'd3,
        PH_OFFING = 3'd4,
        PH_ERR    = 3'd5
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic               prev_req_reg;
    logic               prev_req_next;
    logic               servo_reg;
    logic               servo_next;
    logic [7:0]         cw_reg;
    logic [7:0]         cw_next;
    logic [15:0]        sw_reg;
    logic [15:0]        sw_next;
    logic signed [31:0] pos_reg;
    logic signed [31:0] pos_next;
    logic signed [7:0]  act_mode_reg;
    logic signed [7:0]  act_mode_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;
    result_t            out_next;
    result_t            res;

    // Output frees as it is read; with m_tready high, a request can pop each cycle.
    assign pop      = ~q_status.empty & (~out_valid_reg | m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - $bits(result_t))'(0), out_reg};

    // Next state and result for the request at the head of the queue.
    always_comb
    begin
        phase_next    = phase_reg;
        prev_req_next = prev_req_reg;
        servo_next    = servo_reg;
        cw_next       = cw_reg;
        sw_next       = sw_reg;
        pos_next      = pos_reg;
        act_mode_next = act_mode_reg;
        res           = '0;

        case (head_item.cls)
            CLS_LINK_LOST:
            begin
                cw_next        = CW_DISABLE_VOLTAGE;
                res.error_code = ERR_POWERED_ON;
            end
            CLS_POWER:
            begin
                if (head_item.power_request && !prev_req_reg)
                begin
                    // Power-on request.
                    if (!cfg.fieldbus_ready)
                    begin
                        res.error_code = ERR_FIELDBUS_INIT;
                    end
                    else
                    begin
                        phase_next    = PH_EN_ON;
                        prev_req_next = 1'b1;
                    end
                end
                else
                begin
                    prev_req_next = head_item.power_request;
                    if (prev_req_reg && !head_item.power_request)
                    begin
                        // Power-off request.
                        servo_next = 1'b0;
                        phase_next = PH_EN_OFF;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_EN_ON:
                            begin
                                if ((sw_reg & SW_MASK_7F) == SW_OP_EN)
                                begin
                                    res.done_res = 1'b1;
                                    servo_next   = 1'b1;
                                    phase_next   = PH_ON;
                                end
                                else if ((sw_reg & SW_MASK_6F) == SW_QSTOP)
                                begin
                                    cw_next = CW_DISABLE_VOLTAGE;
                                end
                                else if ((sw_reg & SW_MASK_4F) == SW_NOT_RDY)
                                begin
                                    cw_next = CW_FAULT_RESET;
                                end
                                else if ((sw_reg & SW_MASK_4F) == SW_SW_DIS)
                                begin
                                    cw_next = CW_SHUTDOWN;
                                end
                                else if ((sw_reg & SW_MASK_7F) == SW_RDY)
                                begin
                                    cw_next = CW_SWITCH_ON;
                                end
                                else if ((sw_reg & SW_MASK_7B) == SW_SW_ON)
                                begin
                                    res.position_write  = 1'b1;
                                    res.target_position = pos_reg;
                                    res.mode_write      = 1'b1;
                                    res.mode_select     = MSEL_CSP;
                                    cw_next             = CW_ENABLE_OP;
                                end
                                else if (drive_faulted(sw_reg))
                                begin
                                    cw_next = CW_FAULT_RESET;
                                end
                                else
                                begin
                                    servo_next     = 1'b0;
                                    phase_next     = PH_ERR;
                                    res.error_code = ERR_POWER_ON;
                                end
                            end
                            PH_ON:
                            begin
                                if (drive_faulted(sw_reg))
                                begin
                                    cw_next        = CW_DISABLE_VOLTAGE;
                                    servo_next     = 1'b0;
                                    phase_next     = PH_ERR;
                                    res.error_code = ERR_POWERED_ON;
                                end
                                else
                                begin
                                    res.done_res = 1'b1;
                                end
                            end
                            PH_EN_OFF:
                            begin
                                cw_next    = CW_SHUTDOWN;
                                phase_next = PH_OFFING;
                            end
                            PH_OFFING:
                            begin
                                cw_next = CW_SHUTDOWN;
                                if (drive_faulted(sw_reg))
                                begin
                                    servo_next     = 1'b0;
                                    res.error_code = ERR_POWER_OFF;
                                end
                                else if ((sw_reg & SW_MASK_7F) == SW_RDY)
                                begin
                                    servo_next   = 1'b0;
                                    res.done_res = 1'b1;
                                    phase_next   = PH_OFF;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
            CLS_RESET:
            begin
                // Outside the error phase a reset simply returns to powered off.
                if (phase_reg == PH_ERR)
                begin
                    if (drive_faulted(sw_reg))
                    begin
                        cw_next = CW_FAULT_RESET;
                    end
                    else if ((sw_reg & SW_MASK_4F) == SW_SW_DIS)
                    begin
                        phase_next   = PH_OFF;
                        res.done_res = 1'b1;
                    end
                end
                else
                begin
                    phase_next   = PH_OFF;
                    res.done_res = 1'b1;
                end
            end
            CLS_BUS:
            begin
                sw_next = head_item.drive_status;
                if (cfg.fieldbus_ready)
                begin
                    pos_next      = head_item.actual_position;
                    act_mode_next = head_item.actual_mode;
                    if (servo_reg)
                    begin
                        res.mode_write = 1'b1;
                        case (cfg.drive_mode)
                            DM_CSP:
                            begin
                                res.position_write  = 1'b1;
                                res.target_position = head_item.submit_position;
                                res.mode_select     = MSEL_CSP;
                                cw_next             = cw_reg & CW_CLEAR_HOME;
                            end
                            DM_CSV:
                            begin
                                res.velocity_write  = 1'b1;
                                res.target_velocity = head_item.submit_velocity;
                                res.mode_select     = MSEL_CSV;
                                cw_next             = cw_reg & CW_CLEAR_HOME;
                            end
                            DM_CST:
                            begin
                                res.torque_write  = 1'b1;
                                res.target_torque = head_item.submit_torque;
                                res.mode_select   = MSEL_CST;
                            end
                            default:
                            begin
                                res.mode_select = MSEL_HOMING;
                                if (cfg.home_enable &&
                                    (head_item.actual_mode == ACT_MODE_HOMING))
                                begin
                                    cw_next = cw_reg | CW_HOME_START;
                                end
                                else
                                begin
                                    cw_next = cw_reg & CW_CLEAR_HOME;
                                end
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                res = '0;
            end
        endcase

        res.control_word = cw_next;
        res.servo_on     = servo_next;
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Sequencer state, drive state and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OFF;
            prev_req_reg  <= 1'b0;
            servo_reg     <= 1'b0;
            cw_reg        <= '0;
            sw_reg        <= '0;
            pos_reg       <= '0;
            act_mode_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg    <= phase_next;
                prev_req_reg <= prev_req_next;
                servo_reg    <= servo_next;
                cw_reg       <= cw_next;
                sw_reg       <= sw_next;
                pos_reg      <= pos_next;
                act_mode_reg <= act_mode_next;
            end
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

FILE: design/cia402_drive_power_sequencer.sv
// Top level of the CiA 402 drive power sequencer: register port and part wiring.
`timescale 1ns / 1ps

// Channel    Direction  Handshake                          Payload
// s_*        in         s_tvalid / s_tready                 s_tuser kind, s_tdata fields
// m_*        out        m_tvalid / m_tready                 m_tdata result fields
// APB        in/out     psel & penable & pwrite (pready=1)  paddr, pwdata, prdata
//
// Sustained rate is one request per clock while the sink holds m_tready high: the back
// part updates the power sequence state and writes the output register for each request.
// With the queue empty and the output free, a request is first written into a queue
// slot and then, from the head of the queue, into the output register on m_tdata.
// Reset clears the sequence state, the queue and the output register.
// A four-entry queue absorbs output stalls; s_tready falls only when it is full.

module cia402_drive_power_sequencer
    import cdps_pkg::*;
#(
    parameter int QUEUE_DEPTH = CDPS_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata from bit 0: power_request, drive_status, link_up,
    // actual_position, actual_mode, submit_position, submit_velocity, submit_torque
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type
    input  logic [S_TUSER_W-1:0]  s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: control_word, error_code, done_res, servo_on,
    // position_write, target_position, velocity_write, target_velocity,
    // torque_write, target_torque, mode_write, mode_select
    output logic [M_TDATA_W-1:0]  m_tdata
);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    reg_index_t    reg_sel;
    logic          wr_en;
    queue_status_t q_status;
    logic          push;
    item_t         push_item;
    logic          pop;
    item_t         head_item;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = reg_index_t'(paddr[3:2]);

    // Register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_DRIVE_MODE:     cfg_next.drive_mode = drive_mode_t'(pwdata[1:0]);
                REG_FIELDBUS_READY: cfg_next.fieldbus_ready = pwdata[0];
                REG_HOME_ENABLE:    cfg_next.home_enable = pwdata[0];
                REG_MAX_PROFILE_V:  cfg_next.max_profile_velocity = pwdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register reads.
    always_comb
    begin
        case (reg_sel)
            REG_DRIVE_MODE:     prdata = {30'd0, cfg_reg.drive_mode};
            REG_FIELDBUS_READY: prdata = {31'd0, cfg_reg.fieldbus_ready};
            REG_HOME_ENABLE:    prdata = {31'd0, cfg_reg.home_enable};
            REG_MAX_PROFILE_V:  prdata = cfg_reg.max_profile_velocity;
            default:            prdata = '0;
        endcase
    end

    cdps_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    cdps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    cdps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .head_item (head_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: design/cdps_checker.sv
// Port-level checks of the drive power sequencer and their binding.
`timescale 1ns / 1ps

module cdps_checker
    import cdps_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A result waiting for the sink keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A completed operation never carries an error code.
    a_done_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11] |-> m_tdata[10:8] == ERR_NONE)
        else $error("done reported together with an error");

    // At most one setpoint is written per request, and only with a mode write.
    a_one_setpoint: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[13] || m_tdata[46] || m_tdata[79]) |->
            $onehot({m_tdata[13], m_tdata[46], m_tdata[79]}) && m_tdata[96])
        else $error("setpoint write without a single mode write");

    // Velocity and torque setpoints go out only while the servo is on.
    a_servo_writes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[46] || m_tdata[79]) |-> m_tdata[12])
        else $error("velocity or torque written with the servo off");

endmodule

bind cia402_drive_power_sequencer cdps_checker u_cdps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
